// ===== src/sfr_pkg.sv =====
`default_nettype none

package sfr_pkg;

    // Default bitmap size and fixed field widths
    localparam int WIDTH_DEF  = 64;
    localparam int HEIGHT_DEF = 32;

    localparam int REQ_W      = 3;
    localparam int POS_W      = 8;
    localparam int LEN_W      = 7;
    localparam int ROW_IDX_W  = 5;
    localparam int ROW_BITS_W = 64;

    // Signed working width for coordinates and span ends
    localparam int COORD_W    = 10;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [REQ_W-1:0] {
        REQ_POINT   = 3'd0,
        REQ_RECT    = 3'd1,
        REQ_DIAMOND = 3'd2,
        REQ_CLEAR   = 3'd3,
        REQ_ROW     = 3'd4
    } t_req;

endpackage

`default_nettype wire

// ===== src/sfr_if.sv =====
`default_nettype none

interface sfr_req_if;
    logic                               valid;
    logic                               ready;
    logic        [sfr_pkg::REQ_W-1:0]     req_type;
    logic signed [sfr_pkg::POS_W-1:0]     x_pos;
    logic signed [sfr_pkg::POS_W-1:0]     y_pos;
    logic        [sfr_pkg::LEN_W-1:0]     rect_width;
    logic        [sfr_pkg::LEN_W-1:0]     rect_height;
    logic        [sfr_pkg::LEN_W-1:0]     radius_len;
    logic        [sfr_pkg::ROW_IDX_W-1:0] row_index;

    modport source (
        output valid, req_type, x_pos, y_pos, rect_width, rect_height, radius_len,
               row_index,
        input  ready
    );

    modport sink (
        input  valid, req_type, x_pos, y_pos, rect_width, rect_height, radius_len,
               row_index,
        output ready
    );
endinterface

interface sfr_row_if;
    logic                              valid;
    logic                              ready;
    logic [sfr_pkg::ROW_BITS_W-1:0]    row_bits;
    logic [sfr_pkg::ROW_IDX_W-1:0]     row_number;

    modport source (output valid, row_bits, row_number, input ready);
    modport sink   (input valid, row_bits, row_number, output ready);
endinterface

`default_nettype wire

// ===== src/sfr_span_gen.sv =====
`default_nettype none

module sfr_span_gen #(
    parameter int WIDTH = sfr_pkg::WIDTH_DEF
) (
    input  wire sfr_pkg::t_coord  i_lo,
    input  wire sfr_pkg::t_coord  i_hi,
    output logic [WIDTH-1:0]      o_mask
);
    import sfr_pkg::*;

    localparam logic [WIDTH-1:0] L_ONES    = '1;
    localparam t_coord           L_COL_MAX = t_coord'(WIDTH - 1);

    logic [COORD_W-1:0] top_gap;

    // Ends arrive clipped to the row; an empty span gives no bits
    always_comb begin
        top_gap = COORD_W'(L_COL_MAX - i_hi);
        if (i_lo > i_hi) begin
            o_mask = '0;
        end else begin
            o_mask = (L_ONES << i_lo) & (L_ONES >> top_gap);
        end
    end

endmodule

`default_nettype wire

// ===== src/shape_fill_rasterizer_top.sv =====
`default_nettype none

// Shape fill rasterizer: a WIDTH by HEIGHT one-bit bitmap driven by commands.
// Input channel i_req carries one command per beat: set a point, fill a
// rectangle, fill a diamond (|dx|+|dy| <= radius), clear the bitmap, or read
// one row. Off-bitmap pixels are clipped; unknown commands are dropped.
// Output channel o_row carries one beat per read row command: the row's bits
// (zero above WIDTH, all zero for a row at or past HEIGHT) and its index.
// A fill walks the rows it covers, one row per cycle through a shared span
// generator and a read-modify-write pipeline on the row memory. A command
// covering n bitmap rows holds i_req.ready low through S_SETUP, the n rows
// of S_RUN and S_DRAIN (only through S_SETUP when no row is hit); at most
// HEIGHT rows are walked. Clear and unknown commands leave i_req.ready high.
// A read row passes S_RD and then S_RD_OUT, which loads o_row.valid and
// frees the block for the next command. If the receiver stalls, the
// beat is held and further commands are still taken; a second read row waits
// for the output register to free up.
// Reset clears every pixel at once through per-row valid bits, so no clearing
// pass follows reset; the block is ready as soon as reset releases.
module shape_fill_rasterizer_top #(
    parameter int WIDTH  = sfr_pkg::WIDTH_DEF,
    parameter int HEIGHT = sfr_pkg::HEIGHT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sfr_req_if.sink    i_req,
    sfr_row_if.source  o_row
);
    import sfr_pkg::*;

    localparam int     L_ROW_W   = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
    localparam t_coord L_ROW_MAX = t_coord'(HEIGHT - 1);
    localparam t_coord L_COL_MAX = t_coord'(WIDTH - 1);
    localparam t_coord L_ONE     = t_coord'(1);
    localparam t_coord L_ZERO    = t_coord'(0);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_DRAIN,
        S_RD,
        S_RD_OUT
    } t_state;

    t_state r_state;

    // Latched command
    t_req                   r_type;
    logic signed [POS_W-1:0] r_x;
    logic signed [POS_W-1:0] r_y;
    logic [LEN_W-1:0]       r_w;
    logic [LEN_W-1:0]       r_h;
    logic [LEN_W-1:0]       r_r;
    logic [ROW_IDX_W-1:0]   r_row_num;
    logic [L_ROW_W-1:0]     r_row_addr;
    logic                   r_row_ok;

    // Row walk
    logic [L_ROW_W-1:0]     r_j;
    logic [L_ROW_W-1:0]     r_end;

    // Stage A: clipped span ends; stage B: mask and read data
    logic                   r_a_vld;
    logic [L_ROW_W-1:0]     r_a_addr;
    t_coord                 r_a_lo;
    t_coord                 r_a_hi;
    logic                   r_b_vld;
    logic [L_ROW_W-1:0]     r_b_addr;
    logic [WIDTH-1:0]       r_b_mask;

    // Row memory and per-row valid bits
    logic [WIDTH-1:0]       r_mem [HEIGHT];
    logic [HEIGHT-1:0]      r_live;
    logic [WIDTH-1:0]       r_rd_data;
    logic                   r_rd_live;

    // Output register
    logic                   r_o_vld;
    logic [ROW_BITS_W-1:0]  r_o_bits;
    logic [ROW_IDX_W-1:0]   r_o_num;

    t_coord s_x, s_y, s_w, s_h, s_r, s_j;
    t_coord row_lo, row_hi, row_first, row_last;
    logic   setup_empty;
    t_coord dy, ady, half, span_lo, span_hi;
    t_coord n_a_lo, n_a_hi;
    logic [WIDTH-1:0]   n_b_mask;
    logic [WIDTH-1:0]   n_wr_data;
    logic               rd_en;
    logic [L_ROW_W-1:0] rd_addr;
    logic [7:0]         row_ext;
    logic               req_fire;
    logic               out_free;

    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign out_free    = !r_o_vld || o_row.ready;
    assign row_ext     = {3'b000, i_req.row_index};

    assign o_row.valid      = r_o_vld;
    assign o_row.row_bits   = r_o_bits;
    assign o_row.row_number = r_o_num;

    // Extend latched fields to the working width
    always_comb begin
        s_x = {{(COORD_W-POS_W){r_x[POS_W-1]}}, r_x};
        s_y = {{(COORD_W-POS_W){r_y[POS_W-1]}}, r_y};
        s_w = {{(COORD_W-LEN_W){1'b0}}, r_w};
        s_h = {{(COORD_W-LEN_W){1'b0}}, r_h};
        s_r = {{(COORD_W-LEN_W){1'b0}}, r_r};
        s_j = {{(COORD_W-L_ROW_W){1'b0}}, r_j};
    end

    // Row range of the shape, clipped to the bitmap
    always_comb begin
        setup_empty = 1'b0;
        case (r_type)
            REQ_RECT: begin
                row_lo      = s_y;
                row_hi      = s_y + s_h - L_ONE;
                setup_empty = (r_w == '0) || (r_h == '0);
            end
            REQ_DIAMOND: begin
                row_lo = s_y - s_r;
                row_hi = s_y + s_r;
            end
            default: begin
                row_lo = s_y;
                row_hi = s_y;
            end
        endcase
        row_first = (row_lo < L_ZERO) ? L_ZERO : row_lo;
        row_last  = (row_hi > L_ROW_MAX) ? L_ROW_MAX : row_hi;
        if (row_first > row_last) begin
            setup_empty = 1'b1;
        end
    end

    // Span of the current row, clipped to the row
    always_comb begin
        dy   = s_j - s_y;
        ady  = (dy < L_ZERO) ? -dy : dy;
        half = s_r - ady;
        case (r_type)
            REQ_RECT: begin
                span_lo = s_x;
                span_hi = s_x + s_w - L_ONE;
            end
            REQ_DIAMOND: begin
                span_lo = s_x - half;
                span_hi = s_x + half;
            end
            default: begin
                span_lo = s_x;
                span_hi = s_x;
            end
        endcase
        n_a_lo = (span_lo < L_ZERO) ? L_ZERO : span_lo;
        n_a_hi = (span_hi > L_COL_MAX) ? L_COL_MAX : span_hi;
    end

    sfr_span_gen #(
        .WIDTH (WIDTH)
    ) u_span (
        .i_lo   (r_a_lo),
        .i_hi   (r_a_hi),
        .o_mask (n_b_mask)
    );

    // One read port shared by the fill pipeline and row readback
    assign rd_en     = r_a_vld || (r_state == S_RD);
    assign rd_addr   = (r_state == S_RD) ? r_row_addr : r_a_addr;
    assign n_wr_data = (r_rd_live ? r_rd_data : '0) | r_b_mask;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (r_b_vld) begin
            r_mem[r_b_addr] <= n_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_live  <= '0;
        end else begin
            if (rd_en) begin
                r_rd_live <= r_live[rd_addr];
            end

            // Stage B: build the mask alongside the row read
            r_b_vld <= r_a_vld;
            if (r_a_vld) begin
                r_b_addr <= r_a_addr;
                r_b_mask <= n_b_mask;
            end
            if (r_b_vld) begin
                r_live[r_b_addr] <= 1'b1;
            end

            // Load a new beat when the register frees up, else drop the taken one
            if ((r_state == S_RD_OUT) && out_free) begin
                r_o_vld <= 1'b1;
            end else if (o_row.ready) begin
                r_o_vld <= 1'b0;
            end

            r_a_vld <= (r_state == S_RUN);

            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_type     <= t_req'(i_req.req_type);
                        r_x        <= i_req.x_pos;
                        r_y        <= i_req.y_pos;
                        r_w        <= i_req.rect_width;
                        r_h        <= i_req.rect_height;
                        r_r        <= i_req.radius_len;
                        r_row_num  <= i_req.row_index;
                        r_row_addr <= row_ext[L_ROW_W-1:0];
                        r_row_ok   <= (int'(i_req.row_index) < HEIGHT);
                        case (t_req'(i_req.req_type))
                            REQ_POINT, REQ_RECT, REQ_DIAMOND: r_state <= S_SETUP;
                            REQ_CLEAR:                        r_live  <= '0;
                            REQ_ROW:                          r_state <= S_RD;
                            default:                          r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SETUP: begin
                    r_j   <= row_first[L_ROW_W-1:0];
                    r_end <= row_last[L_ROW_W-1:0];
                    r_state <= setup_empty ? S_IDLE : S_RUN;
                end
                S_RUN: begin
                    r_a_addr <= r_j;
                    r_a_lo   <= n_a_lo;
                    r_a_hi   <= n_a_hi;
                    if (r_j == r_end) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_j <= r_j + L_ROW_W'(1);
                    end
                end
                S_DRAIN: begin
                    // Hold until the last row has been written back
                    if (!r_a_vld && !r_b_vld) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_RD_OUT;
                end
                S_RD_OUT: begin
                    if (out_free) begin
                        r_o_num  <= r_row_num;
                        r_o_bits <= (r_row_ok && r_rd_live) ? ROW_BITS_W'(r_rd_data) : '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_ready_pipe_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (!r_a_vld && !r_b_vld)
    ) else $error("command taken while a row write is in flight");

    a_write_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> (int'(r_b_addr) < HEIGHT)
    ) else $error("row write beyond the bitmap");

    a_far_row_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_row.valid && (int'(o_row.row_number) >= HEIGHT)) |-> (o_row.row_bits == '0)
    ) else $error("row past the bitmap returned set pixels");

    a_out_from_read: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_row.valid) |-> ($past(r_state) == S_RD_OUT)
    ) else $error("row beat raised outside readback");
`endif

endmodule

`default_nettype wire
